// File: design/meshlet_vertex_dedup_packer_core_assert.svh
// ----------------------------------------------------------------------------
// Meshlet vertex dedup packer assertion macros
// Shorthand for clocked assertions that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MESHLET_VERTEX_DEDUP_PACKER_CORE_ASSERT_SVH
`define MESHLET_VERTEX_DEDUP_PACKER_CORE_ASSERT_SVH

// Same-cycle implication.
`define MVDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MVDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mvdp_pkg.sv
// ----------------------------------------------------------------------------
// Meshlet vertex dedup packer package
// Sizes, register indexes, command codes and the control bundle shared by
// the packer modules.
// ----------------------------------------------------------------------------
package mvdp_pkg;

  // Storage sizes.
  localparam int MAX_VERTS   = 64;
  localparam int MAX_PRIMS   = 256;
  localparam int AW          = $clog2(MAX_VERTS);
  localparam int CW          = $clog2(MAX_VERTS + 1);
  localparam int PCW         = $clog2(MAX_PRIMS + 1);

  // Field widths.
  localparam int CORNER_W    = 32;
  localparam int SLOT_W      = 6;
  localparam int VTOT_W      = 7;
  localparam int PTOT_W      = 9;
  localparam int VLIM_W      = 7;
  localparam int PLIM_W      = 9;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;

  // Compare widths that hold both a count and a limit.
  localparam int VL_W        = (CW > VLIM_W) ? CW : VLIM_W;
  localparam int PL_W        = (PCW > PLIM_W) ? PCW : PLIM_W;

  localparam int NUM_CORNERS = 3;
  localparam int CSEL_W      = 2;
  localparam logic [CSEL_W-1:0] LAST_CORNER = CSEL_W'(NUM_CORNERS - 1);

  localparam logic [VLIM_W-1:0] VLIM_RESET = 7'd64;
  localparam logic [PLIM_W-1:0] PLIM_RESET = 9'd126;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMITIVE_LIMIT = 1'b1;

  // Item kinds.
  localparam logic KIND_TRIANGLE    = 1'b0;
  localparam logic KIND_NEW_MESHLET = 1'b1;

  // Controller to matcher.
  typedef struct packed {
    logic              load;
    logic              cmp_vld;
    logic [AW-1:0]     cmp_idx;
    logic              app_en;
    logic [CSEL_W-1:0] app_sel;
    logic [AW-1:0]     app_slot;
  } mvdp_ctl_t;

endpackage

// File: design/mvdp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mvdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mvdp_match.sv
// ----------------------------------------------------------------------------
// Meshlet vertex dedup packer corner matcher
// Holds the three corners of the triangle in work, compares each stored
// vertex read from the table against them and keeps found flags and slots.
// ----------------------------------------------------------------------------
module mvdp_match (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  mvdp_pkg::mvdp_ctl_t                               ctl_i,
  input  logic [mvdp_pkg::CORNER_W-1:0]                     corner_a_i,
  input  logic [mvdp_pkg::CORNER_W-1:0]                     corner_b_i,
  input  logic [mvdp_pkg::CORNER_W-1:0]                     corner_c_i,
  input  logic [mvdp_pkg::CORNER_W-1:0]                     rdata_i,
  output logic [mvdp_pkg::NUM_CORNERS-1:0]                  found_o,
  output logic [mvdp_pkg::NUM_CORNERS-1:0][mvdp_pkg::AW-1:0] slot_o,
  output logic [mvdp_pkg::CORNER_W-1:0]                     app_data_o
);

  logic [mvdp_pkg::NUM_CORNERS-1:0][mvdp_pkg::CORNER_W-1:0] corner_q;
  logic [mvdp_pkg::NUM_CORNERS-1:0]                         found_q;
  logic [mvdp_pkg::NUM_CORNERS-1:0][mvdp_pkg::AW-1:0]       slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (ctl_i.load) begin
      found_q <= '0;
    end else if (ctl_i.cmp_vld) begin
      for (int j = 0; j < mvdp_pkg::NUM_CORNERS; j++) begin
        if (rdata_i == corner_q[j]) begin
          found_q[j] <= 1'b1;
        end
      end
    end
  end

  // Entries are scanned in ascending order, so the highest match wins.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      corner_q <= {corner_c_i, corner_b_i, corner_a_i};
      slot_q   <= '0;
    end else begin
      for (int j = 0; j < mvdp_pkg::NUM_CORNERS; j++) begin
        if (ctl_i.cmp_vld && (rdata_i == corner_q[j])) begin
          slot_q[j] <= ctl_i.cmp_idx;
        end
        if (ctl_i.app_en && (ctl_i.app_sel == mvdp_pkg::CSEL_W'(j))) begin
          slot_q[j] <= ctl_i.app_slot;
        end
      end
    end
  end

  assign found_o    = found_q;
  assign slot_o     = slot_q;
  assign app_data_o = corner_q[ctl_i.app_sel];

endmodule

// File: design/meshlet_vertex_dedup_packer_core.sv
// ----------------------------------------------------------------------------
// Meshlet vertex dedup packer
// Adds triangles to a meshlet, sharing vertices that are already stored and
// appending new ones; a command starts a new empty meshlet.
//
//   Channel   Control              Payload
//   --------  -------------------  -----------------------------------------
//   command   start_i / busy_o     kind_i, corner_a_i, corner_b_i, corner_c_i
//   result    done_o (strobe)      accepted_o, local_*_o, *_total_o,
//                                  meshlet_full_o
//   config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// V is the vertex count at the transaction. A new-meshlet command or a full refusal
// is reported in the next cycle; other triangles scan V entries through the table's
// single read port, then drain and evaluate; an empty meshlet goes straight to evaluate.
// An overflow refusal is reported from evaluate; an accepted triangle appends its
// unmatched corners, then is reported. busy_o is high while a triangle is in work and
// results cannot be held off. Only entries below V are read, so no clearing on reset.
// ----------------------------------------------------------------------------
module meshlet_vertex_dedup_packer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            kind_i,
  input  logic [mvdp_pkg::CORNER_W-1:0]   corner_a_i,
  input  logic [mvdp_pkg::CORNER_W-1:0]   corner_b_i,
  input  logic [mvdp_pkg::CORNER_W-1:0]   corner_c_i,
  output logic                            done_o,
  output logic                            accepted_o,
  output logic [mvdp_pkg::SLOT_W-1:0]     local_a_o,
  output logic [mvdp_pkg::SLOT_W-1:0]     local_b_o,
  output logic [mvdp_pkg::SLOT_W-1:0]     local_c_o,
  output logic [mvdp_pkg::VTOT_W-1:0]     vertex_total_o,
  output logic [mvdp_pkg::PTOT_W-1:0]     primitive_total_o,
  output logic                            meshlet_full_o,
  input  logic                            cfg_we_i,
  input  logic [mvdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mvdp_pkg::CFG_W-1:0]      cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_APPEND
  } state_e;

  state_e                            state_q, state_d;
  logic [mvdp_pkg::CW-1:0]           vcnt_q, vcnt_d;
  logic [mvdp_pkg::PCW-1:0]          pcnt_q, pcnt_d;
  logic [mvdp_pkg::AW-1:0]           rd_idx_q, rd_idx_d;
  logic [mvdp_pkg::CSEL_W-1:0]       app_j_q, app_j_d;
  logic                              cmp_vld_q;
  logic [mvdp_pkg::AW-1:0]           cmp_idx_q;
  logic                              done_q, done_d;
  logic                              acc_q, acc_d;
  logic                              full_q, full_d;
  logic [mvdp_pkg::VLIM_W-1:0]       vlim_q;
  logic [mvdp_pkg::PLIM_W-1:0]       plim_q;

  logic [mvdp_pkg::VL_W-1:0]         vlim_eff;
  logic [mvdp_pkg::PL_W-1:0]         plim_eff;
  logic [1:0]                        fresh;
  logic [mvdp_pkg::VL_W:0]           vsum;
  logic                              ram_we;
  mvdp_pkg::mvdp_ctl_t               ctl;

  logic [mvdp_pkg::NUM_CORNERS-1:0]                   found;
  logic [mvdp_pkg::NUM_CORNERS-1:0][mvdp_pkg::AW-1:0] slot;
  logic [mvdp_pkg::CORNER_W-1:0]                      app_data;
  logic [mvdp_pkg::CORNER_W-1:0]                      rdata;

  assign vlim_eff = (mvdp_pkg::VL_W'(vlim_q) > mvdp_pkg::VL_W'(mvdp_pkg::MAX_VERTS)) ?
                    mvdp_pkg::VL_W'(mvdp_pkg::MAX_VERTS) : mvdp_pkg::VL_W'(vlim_q);
  assign plim_eff = (mvdp_pkg::PL_W'(plim_q) > mvdp_pkg::PL_W'(mvdp_pkg::MAX_PRIMS)) ?
                    mvdp_pkg::PL_W'(mvdp_pkg::MAX_PRIMS) : mvdp_pkg::PL_W'(plim_q);

  function automatic logic is_full(input logic [mvdp_pkg::CW-1:0]  vc,
                                   input logic [mvdp_pkg::PCW-1:0] pc);
    return (mvdp_pkg::VL_W'(vc) >= vlim_eff) || (mvdp_pkg::PL_W'(pc) >= plim_eff);
  endfunction

  // Corners that matched nothing in the table must be appended.
  assign fresh = 2'd3 - 2'($countones(found));
  assign vsum  = (mvdp_pkg::VL_W + 1)'(vcnt_q) + (mvdp_pkg::VL_W + 1)'(fresh);

  always_comb begin
    state_d     = state_q;
    vcnt_d      = vcnt_q;
    pcnt_d      = pcnt_q;
    rd_idx_d    = rd_idx_q;
    app_j_d     = app_j_q;
    done_d      = 1'b0;
    acc_d       = acc_q;
    full_d      = full_q;
    ram_we      = 1'b0;
    ctl         = '0;
    ctl.cmp_vld = cmp_vld_q;
    ctl.cmp_idx = cmp_idx_q;
    ctl.app_sel = app_j_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i == mvdp_pkg::KIND_NEW_MESHLET) begin
            vcnt_d = '0;
            pcnt_d = '0;
            done_d = 1'b1;
            acc_d  = 1'b0;
            full_d = is_full('0, '0);
          end else if (is_full(vcnt_q, pcnt_q)) begin
            done_d = 1'b1;
            acc_d  = 1'b0;
            full_d = 1'b1;
          end else begin
            ctl.load = 1'b1;
            rd_idx_d = '0;
            state_d  = (vcnt_q == '0) ? ST_EVAL : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_idx_d = rd_idx_q + 1'b1;
        if (mvdp_pkg::CW'(rd_idx_q) == (vcnt_q - 1'b1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (vsum <= (mvdp_pkg::VL_W + 1)'(vlim_eff)) begin
          app_j_d = '0;
          state_d = ST_APPEND;
        end else begin
          done_d  = 1'b1;
          acc_d   = 1'b0;
          full_d  = is_full(vcnt_q, pcnt_q);
          state_d = ST_IDLE;
        end
      end
      ST_APPEND: begin
        if (!found[app_j_q]) begin
          ram_we       = 1'b1;
          ctl.app_en   = 1'b1;
          ctl.app_slot = vcnt_q[mvdp_pkg::AW-1:0];
          vcnt_d       = vcnt_q + 1'b1;
        end
        if (app_j_q == mvdp_pkg::LAST_CORNER) begin
          pcnt_d  = pcnt_q + 1'b1;
          done_d  = 1'b1;
          acc_d   = 1'b1;
          full_d  = is_full(vcnt_d, pcnt_d);
          state_d = ST_IDLE;
        end else begin
          app_j_d = app_j_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcnt_q    <= '0;
      pcnt_q    <= '0;
      rd_idx_q  <= '0;
      app_j_q   <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      done_q    <= 1'b0;
      acc_q     <= 1'b0;
      full_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      vcnt_q    <= vcnt_d;
      pcnt_q    <= pcnt_d;
      rd_idx_q  <= rd_idx_d;
      app_j_q   <= app_j_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      cmp_idx_q <= rd_idx_q;
      done_q    <= done_d;
      acc_q     <= acc_d;
      full_q    <= full_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q <= mvdp_pkg::VLIM_RESET;
      plim_q <= mvdp_pkg::PLIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mvdp_pkg::REG_VERTEX_LIMIT:    vlim_q <= cfg_wdata_i[mvdp_pkg::VLIM_W-1:0];
        mvdp_pkg::REG_PRIMITIVE_LIMIT: plim_q <= cfg_wdata_i[mvdp_pkg::PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  mvdp_ram #(
    .WIDTH (mvdp_pkg::CORNER_W),
    .DEPTH (mvdp_pkg::MAX_VERTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (vcnt_q[mvdp_pkg::AW-1:0]),
    .wdata_i (app_data),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  mvdp_match u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .corner_a_i (corner_a_i),
    .corner_b_i (corner_b_i),
    .corner_c_i (corner_c_i),
    .rdata_i    (rdata),
    .found_o    (found),
    .slot_o     (slot),
    .app_data_o (app_data)
  );

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign accepted_o        = acc_q;
  assign local_a_o         = acc_q ? mvdp_pkg::SLOT_W'(slot[0]) : '0;
  assign local_b_o         = acc_q ? mvdp_pkg::SLOT_W'(slot[1]) : '0;
  assign local_c_o         = acc_q ? mvdp_pkg::SLOT_W'(slot[2]) : '0;
  assign vertex_total_o    = mvdp_pkg::VTOT_W'(vcnt_q);
  assign primitive_total_o = mvdp_pkg::PTOT_W'(pcnt_q);
  assign meshlet_full_o    = full_q;

endmodule

// File: design/mvdp_checker.sv
// ----------------------------------------------------------------------------
// Meshlet vertex dedup packer port checker
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`include "meshlet_vertex_dedup_packer_core_assert.svh"

module mvdp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_o,
  input  logic                            kind_i,
  input  logic                            done_o,
  input  logic                            accepted_o,
  input  logic [mvdp_pkg::SLOT_W-1:0]     local_a_o,
  input  logic [mvdp_pkg::SLOT_W-1:0]     local_b_o,
  input  logic [mvdp_pkg::SLOT_W-1:0]     local_c_o,
  input  logic [mvdp_pkg::VTOT_W-1:0]     vertex_total_o,
  input  logic [mvdp_pkg::PTOT_W-1:0]     primitive_total_o,
  input  logic                            meshlet_full_o
);

  // A result only ever follows a transaction or work in progress.
  `MVDP_ASSERT_NOW(a_done_has_cause, done_o,
    $past(busy_o) || $past(start_i && !busy_o), "result without a transaction")

  // A new-meshlet command reports empty totals in the next cycle.
  `MVDP_ASSERT_NEXT(a_new_meshlet_clears,
    start_i && !busy_o && (kind_i == mvdp_pkg::KIND_NEW_MESHLET),
    done_o && !accepted_o && (vertex_total_o == '0) && (primitive_total_o == '0),
    "new meshlet did not clear the counts")

  // Refused items report zero slots.
  `MVDP_ASSERT_NOW(a_refused_zero_slots, done_o && !accepted_o,
    (local_a_o == '0) && (local_b_o == '0) && (local_c_o == '0),
    "refused item has nonzero slots")

  // Accepted slots point inside the meshlet.
  `MVDP_ASSERT_NOW(a_slots_in_range, done_o && accepted_o,
    (mvdp_pkg::VTOT_W'(local_a_o) < vertex_total_o) &&
    (mvdp_pkg::VTOT_W'(local_b_o) < vertex_total_o) &&
    (mvdp_pkg::VTOT_W'(local_c_o) < vertex_total_o) && (primitive_total_o != '0),
    "accepted slot beyond the vertex total")

endmodule

bind meshlet_vertex_dedup_packer_core mvdp_checker u_mvdp_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Meshlet vertex dedup packer testbench
// Streams triangles and new-meshlet commands into the packer under several
// limit settings and sender idle rates. A local copy of the vertex table and
// counts predicts every result, and each strobed result is compared field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic                          kind;
    logic [mvdp_pkg::CORNER_W-1:0] a;
    logic [mvdp_pkg::CORNER_W-1:0] b;
    logic [mvdp_pkg::CORNER_W-1:0] c;
    logic                          drain;
  } mesh_cmd_t;

  typedef struct packed {
    logic                        accepted;
    logic [mvdp_pkg::SLOT_W-1:0] local_a;
    logic [mvdp_pkg::SLOT_W-1:0] local_b;
    logic [mvdp_pkg::SLOT_W-1:0] local_c;
    logic [mvdp_pkg::VTOT_W-1:0] vertex_total;
    logic [mvdp_pkg::PTOT_W-1:0] primitive_total;
    logic                        full;
  } pack_res_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic                           kind_i = mvdp_pkg::KIND_TRIANGLE;
  logic [mvdp_pkg::CORNER_W-1:0]  corner_a_i = '0;
  logic [mvdp_pkg::CORNER_W-1:0]  corner_b_i = '0;
  logic [mvdp_pkg::CORNER_W-1:0]  corner_c_i = '0;
  logic                           cfg_we_i = 1'b0;
  logic [mvdp_pkg::CFG_IDX_W-1:0] cfg_idx_i = mvdp_pkg::REG_VERTEX_LIMIT;
  logic [mvdp_pkg::CFG_W-1:0]     cfg_wdata_i = '0;
  logic                           busy_o;
  logic                           done_o;
  logic                           accepted_o;
  logic [mvdp_pkg::SLOT_W-1:0]    local_a_o;
  logic [mvdp_pkg::SLOT_W-1:0]    local_b_o;
  logic [mvdp_pkg::SLOT_W-1:0]    local_c_o;
  logic [mvdp_pkg::VTOT_W-1:0]    vertex_total_o;
  logic [mvdp_pkg::PTOT_W-1:0]    primitive_total_o;
  logic                           meshlet_full_o;

  meshlet_vertex_dedup_packer_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .corner_a_i        (corner_a_i),
    .corner_b_i        (corner_b_i),
    .corner_c_i        (corner_c_i),
    .done_o            (done_o),
    .accepted_o        (accepted_o),
    .local_a_o         (local_a_o),
    .local_b_o         (local_b_o),
    .local_c_o         (local_c_o),
    .vertex_total_o    (vertex_total_o),
    .primitive_total_o (primitive_total_o),
    .meshlet_full_o    (meshlet_full_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  mesh_cmd_t cmd_q[$];
  pack_res_t exp_pack_q[$];
  int        n_sent = 0;
  int        n_recv = 0;
  int        n_err = 0;
  int        idle_pct = 0;

  // Local copy of the packer state and its limit registers.
  logic [mvdp_pkg::CORNER_W-1:0] vert_tab [mvdp_pkg::MAX_VERTS];
  int                            vert_cnt = 0;
  int                            prim_cnt = 0;
  int                            vert_lim = int'(mvdp_pkg::VLIM_RESET);
  int                            prim_lim = int'(mvdp_pkg::PLIM_RESET);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic pack_res_t pack_item(logic kind, logic [mvdp_pkg::CORNER_W-1:0] ca,
                                          logic [mvdp_pkg::CORNER_W-1:0] cb,
                                          logic [mvdp_pkg::CORNER_W-1:0] cc);
    pack_res_t                     res;
    logic [mvdp_pkg::CORNER_W-1:0] corner [mvdp_pkg::NUM_CORNERS];
    int                            slot [mvdp_pkg::NUM_CORNERS];
    bit                            hit [mvdp_pkg::NUM_CORNERS];
    int                            fresh;
    int                            vlim_eff;
    int                            plim_eff;
    res = '0;
    corner[0] = ca;
    corner[1] = cb;
    corner[2] = cc;
    foreach (slot[j]) begin
      slot[j] = 0;
      hit[j]  = 1'b0;
    end
    vlim_eff = (vert_lim > mvdp_pkg::MAX_VERTS) ? mvdp_pkg::MAX_VERTS : vert_lim;
    plim_eff = (prim_lim > mvdp_pkg::MAX_PRIMS) ? mvdp_pkg::MAX_PRIMS : prim_lim;
    fresh    = mvdp_pkg::NUM_CORNERS;
    if (kind == mvdp_pkg::KIND_NEW_MESHLET) begin
      vert_cnt = 0;
      prim_cnt = 0;
    end else if (vert_cnt < vlim_eff && prim_cnt < plim_eff) begin
      // Later entries overwrite earlier ones, so the highest matching slot wins.
      for (int i = 0; i < vert_cnt; i++) begin
        foreach (corner[j]) begin
          if (vert_tab[i] == corner[j]) begin
            slot[j] = i;
            hit[j]  = 1'b1;
          end
        end
      end
      foreach (hit[j]) begin
        if (hit[j]) fresh--;
      end
      if (vert_cnt + fresh <= vlim_eff) begin
        // Unmatched repeats within one triangle each get their own entry.
        foreach (hit[j]) begin
          if (!hit[j]) begin
            slot[j]            = vert_cnt;
            vert_tab[vert_cnt] = corner[j];
            vert_cnt++;
          end
        end
        prim_cnt++;
        res.accepted = 1'b1;
        res.local_a  = mvdp_pkg::SLOT_W'(slot[0]);
        res.local_b  = mvdp_pkg::SLOT_W'(slot[1]);
        res.local_c  = mvdp_pkg::SLOT_W'(slot[2]);
      end
    end
    res.vertex_total    = mvdp_pkg::VTOT_W'(vert_cnt);
    res.primitive_total = mvdp_pkg::PTOT_W'(prim_cnt);
    res.full            = (vert_cnt >= vlim_eff) || (prim_cnt >= plim_eff);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  // Driver: presents queued commands and records a prediction per transaction.
  always @(posedge clk_i) begin : drv
    bit        fire;
    bit        go;
    mesh_cmd_t nx;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      fire = start_i && !busy_o;
      if (fire) begin
        exp_pack_q = {exp_pack_q, pack_item(kind_i, corner_a_i, corner_b_i, corner_c_i)};
        n_sent <= n_sent + 1;
      end
      if (!start_i || fire) begin
        go = (cmd_q.size() != 0) && ($urandom_range(99) >= idle_pct);
        // A marked command waits until every earlier result has come back.
        if (go && cmd_q[0].drain && (start_i || n_sent != n_recv)) go = 1'b0;
        if (go) begin
          nx = cmd_q.pop_front();
          start_i    <= 1'b1;
          kind_i     <= nx.kind;
          corner_a_i <= nx.a;
          corner_b_i <= nx.b;
          corner_c_i <= nx.c;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each strobed result against the oldest prediction.
  always @(posedge clk_i) begin : mon
    pack_res_t want;
    if (rst_ni && done_o) begin
      if (exp_pack_q.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        n_err++;
      end else begin
        want = exp_pack_q.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted_o));
        check_field("local_a", 32'(want.local_a), 32'(local_a_o));
        check_field("local_b", 32'(want.local_b), 32'(local_b_o));
        check_field("local_c", 32'(want.local_c), 32'(local_c_o));
        check_field("vertex_total", 32'(want.vertex_total), 32'(vertex_total_o));
        check_field("primitive_total", 32'(want.primitive_total),
                    32'(primitive_total_o));
        check_field("meshlet_full", 32'(want.full), 32'(meshlet_full_o));
      end
      n_recv <= n_recv + 1;
    end
  end

  task automatic push_cmd(logic kind, logic [mvdp_pkg::CORNER_W-1:0] a,
                          logic [mvdp_pkg::CORNER_W-1:0] b,
                          logic [mvdp_pkg::CORNER_W-1:0] c);
    mesh_cmd_t cmd;
    cmd = '{kind: kind, a: a, b: b, c: c, drain: 1'b0};
    cmd_q = {cmd_q, cmd};
  endtask

  // Returns once every command is sent and every result is back, plus a margin.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || start_i || n_recv < n_sent);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limits(int vlim, int plim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= mvdp_pkg::REG_VERTEX_LIMIT;
    cfg_wdata_i <= mvdp_pkg::CFG_W'(vlim);
    @(posedge clk_i);
    cfg_idx_i   <= mvdp_pkg::REG_PRIMITIVE_LIMIT;
    cfg_wdata_i <= mvdp_pkg::CFG_W'(plim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vert_lim = vlim & 'h7f;
    prim_lim = plim & 'h1ff;
  endtask

  // Triangles mostly draw corners from a small pool so that meshlets share
  // vertices and fill up; the rest are fresh indices and new-meshlet commands.
  task automatic queue_random(int count);
    logic [mvdp_pkg::CORNER_W-1:0] pool [24];
    mesh_cmd_t                     cmd;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    for (int k = 0; k < count; k++) begin
      cmd       = '0;
      cmd.drain = ($urandom_range(49) == 0);
      cmd.a     = $urandom;
      cmd.b     = $urandom;
      cmd.c     = $urandom;
      if ($urandom_range(34) == 0) begin
        cmd.kind = mvdp_pkg::KIND_NEW_MESHLET;
        if ($urandom_range(1) == 1) begin
          foreach (pool[i]) pool[i] = $urandom;
        end
      end else begin
        cmd.kind = mvdp_pkg::KIND_TRIANGLE;
        if ($urandom_range(9) < 7) cmd.a = pool[$urandom_range(23)];
        if ($urandom_range(9) < 7) cmd.b = pool[$urandom_range(23)];
        if ($urandom_range(9) < 7) cmd.c = pool[$urandom_range(23)];
      end
      cmd_q = {cmd_q, cmd};
    end
  endtask

  initial begin : main
    int ph_vl [7]   = '{64, 127, 20, 3, 64, 1, 33};
    int ph_pl [7]   = '{126, 511, 256, 10, 300, 1, 50};
    int ph_idle [7] = '{0, 58, 0, 21, 58, 0, 21};
    int ph_n [7]    = '{150, 150, 120, 100, 150, 40, 140};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: extreme indices, a fully shared triangle, a repeated
    // corner appended three times, then a corner with several stored matches.
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd5, 32'd5, 32'd5);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd5, 32'hffff_ffff, 32'd7);
    wait_idle();

    // Vertex limit lowered below the current count, then overflow refusals.
    write_limits(5, 126);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd0, 32'd0, 32'd0);
    push_cmd(mvdp_pkg::KIND_NEW_MESHLET, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd1, 32'd2, 32'd3);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd4, 32'd5, 32'd6);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd4, 32'd1, 32'd2);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd9, 32'd9, 32'd1);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd9, 32'd2, 32'd3);
    wait_idle();

    // Zero limits refuse everything; a new meshlet on an empty one.
    write_limits(0, 0);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd1, 32'd2, 32'd3);
    push_cmd(mvdp_pkg::KIND_NEW_MESHLET, 32'd0, 32'd0, 32'd0);
    push_cmd(mvdp_pkg::KIND_NEW_MESHLET, 32'd0, 32'd0, 32'd0);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd1, 32'd2, 32'd3);
    wait_idle();

    // Vertex limit above the table size, single-triangle meshlets.
    write_limits(127, 1);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd7, 32'd8, 32'd9);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'd10, 32'd11, 32'd12);
    push_cmd(mvdp_pkg::KIND_NEW_MESHLET, 32'd0, 32'd0, 32'd0);
    push_cmd(mvdp_pkg::KIND_TRIANGLE, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      write_limits(ph_vl[p], ph_pl[p]);
      idle_pct = ph_idle[p];
      queue_random(ph_n[p]);
      wait_idle();
    end

    if (exp_pack_q.size() != 0) begin
      $error("%0d expected results never arrived", exp_pack_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("meshlet_vertex_dedup_packer_core test passed");
    end else begin
      $display("meshlet_vertex_dedup_packer_core test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("meshlet_vertex_dedup_packer_core test failed");
    $finish;
  end

endmodule
